@@ src/msgpack_value_serializer_top_defines.svh @@
// ---------------------------------------------------------------------------
// msgpack_value_serializer_top_defines
// Assertion macros used by the serializer checker.
// ---------------------------------------------------------------------------
`ifndef MSGPACK_VALUE_SERIALIZER_TOP_DEFINES_SVH
`define MSGPACK_VALUE_SERIALIZER_TOP_DEFINES_SVH

// clocked check, masked while reset is asserted
`define MVS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define MVS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mvs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvs_pkg
// Types and constants of the MessagePack value serializer.
// ---------------------------------------------------------------------------
package mvs_pkg;

    localparam int OPCODE_W   = 4;
    localparam int INT_W      = 64;
    localparam int RAW_W      = 64;
    localparam int LEN_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int DCNT_W     = 4;
    localparam int TCNT_W     = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START   = 4'd0,
        OP_INT     = 4'd1,
        OP_BOOL    = 4'd2,
        OP_F32     = 4'd3,
        OP_F64     = 4'd4,
        OP_STR_HDR = 4'd5,
        OP_BIN_HDR = 4'd6,
        OP_PAYLOAD = 4'd7,
        OP_OBJ_BEG = 4'd8,
        OP_OBJ_END = 4'd9,
        OP_EL_BEG  = 4'd10,
        OP_EL_END  = 4'd11
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEADER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBJ_BEGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OBJ_END      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_BEGIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_END     = 3'd5;

    localparam logic [BYTE_W-1:0] MP_UINT8   = 8'hcc;
    localparam logic [BYTE_W-1:0] MP_UINT16  = 8'hcd;
    localparam logic [BYTE_W-1:0] MP_UINT32  = 8'hce;
    localparam logic [BYTE_W-1:0] MP_UINT64  = 8'hcf;
    localparam logic [BYTE_W-1:0] MP_INT8    = 8'hd0;
    localparam logic [BYTE_W-1:0] MP_INT16   = 8'hd1;
    localparam logic [BYTE_W-1:0] MP_INT32   = 8'hd2;
    localparam logic [BYTE_W-1:0] MP_INT64   = 8'hd3;
    localparam logic [BYTE_W-1:0] MP_FLOAT32 = 8'hca;
    localparam logic [BYTE_W-1:0] MP_FLOAT64 = 8'hcb;
    localparam logic [BYTE_W-1:0] MP_TRUE    = 8'hc3;
    localparam logic [BYTE_W-1:0] MP_FALSE   = 8'hc2;
    localparam logic [2:0]        MP_FIXSTR  = 3'b101;
    localparam logic [BYTE_W-1:0] MP_STR8    = 8'hd9;
    localparam logic [BYTE_W-1:0] MP_STR16   = 8'hda;
    localparam logic [BYTE_W-1:0] MP_STR32   = 8'hdb;
    localparam logic [BYTE_W-1:0] MP_BIN8    = 8'hc4;
    localparam logic [BYTE_W-1:0] MP_BIN16   = 8'hc5;
    localparam logic [BYTE_W-1:0] MP_BIN32   = 8'hc6;
    localparam logic [BYTE_W-1:0] MP_FIXEXT1 = 8'hd4;
    localparam logic [BYTE_W-1:0] MP_FIXEXT2 = 8'hd5;
    localparam logic [BYTE_W-1:0] MP_OPTIONS = 8'h00;

    localparam logic [3:0]        RST_FRAME_HEADER = 4'd0;
    localparam logic [3:0]        RST_FORMAT_VER   = 4'd0;
    localparam logic [BYTE_W-1:0] RST_OBJ_BEGIN    = 8'd0;
    localparam logic [BYTE_W-1:0] RST_OBJ_END      = 8'd1;
    localparam logic [BYTE_W-1:0] RST_ELEM_BEGIN   = 8'd2;
    localparam logic [BYTE_W-1:0] RST_ELEM_END     = 8'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_HEAD = 2'd1,
        ST_DATA = 2'd2,
        ST_TAIL = 2'd3
    } state_t;

    // one item split into header byte, big-endian data bytes and trailer bytes
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] head;
        logic [DCNT_W-1:0] dcnt;
        logic [INT_W-1:0]  word;
        logic [TCNT_W-1:0] tcnt;
        logic [15:0]       tail;
    } enc_t;

    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [DCNT_W-1:0] dcnt;
    } int_form_t;

endpackage

@@ src/mvs_in_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvs_in_if
// Input channel: one typed value per word.
// ---------------------------------------------------------------------------
interface mvs_in_if;

    logic                                valid;
    logic                                ready;
    logic [mvs_pkg::OPCODE_W-1:0]        opcode;
    logic signed [mvs_pkg::INT_W-1:0]    int_value;
    logic [mvs_pkg::RAW_W-1:0]           raw_bits;
    logic                                flag;
    logic [mvs_pkg::LEN_W-1:0]           length;
    logic [mvs_pkg::BYTE_W-1:0]          payload;

    modport source (output valid, opcode, int_value, raw_bits, flag, length, payload,
                    input ready);
    modport sink   (input valid, opcode, int_value, raw_bits, flag, length, payload,
                    output ready);

endinterface

@@ src/mvs_out_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvs_out_if
// Output channel: one encoded byte per word with a last mark.
// ---------------------------------------------------------------------------
interface mvs_out_if;

    logic                        valid;
    logic                        ready;
    logic [mvs_pkg::BYTE_W-1:0]  out_byte;
    logic                        last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);

endinterface

@@ src/msgpack_value_serializer_top.sv @@
`timescale 1ns / 1ps
// An accepted item's first byte goes from the head register to the output register once the output is free.
// The input is ready only while idle, so a new item is taken only after the previous item's last byte is
// in the output register; the byte shift register emits one byte per cycle while the output is not stalled.
// Unused opcodes are accepted and dropped without leaving the idle state.
// Reset: idle, output empty, config registers at their defaults.
// ---------------------------------------------------------------------------
// msgpack_value_serializer_top
// Serializes typed values into MessagePack bytes, one byte per output word.
// ---------------------------------------------------------------------------
module msgpack_value_serializer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mvs_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [mvs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    mvs_in_if.sink                              in_ch,
    mvs_out_if.source                           out_ch
);

    logic [3:0]                        frame_header_reg;
    logic [3:0]                        format_version_reg;
    logic [mvs_pkg::BYTE_W-1:0]        obj_begin_reg;
    logic [mvs_pkg::BYTE_W-1:0]        obj_end_reg;
    logic [mvs_pkg::BYTE_W-1:0]        elem_begin_reg;
    logic [mvs_pkg::BYTE_W-1:0]        elem_end_reg;

    mvs_pkg::state_t                   state_reg, state_next;
    logic [mvs_pkg::BYTE_W-1:0]        head_reg;
    logic [mvs_pkg::INT_W-1:0]         data_reg;
    logic [mvs_pkg::DCNT_W-1:0]        dcnt_reg;
    logic [15:0]                       tail_reg;
    logic [mvs_pkg::TCNT_W-1:0]        tcnt_reg;
    logic [mvs_pkg::BYTE_W-1:0]        obyte_reg;
    logic                              olast_reg;
    logic                              ovalid_reg;

    mvs_pkg::enc_t                     enc;
    mvs_pkg::int_form_t                ifrm;
    logic                              accept;
    logic                              step;
    logic [mvs_pkg::BYTE_W-1:0]        cur_byte;
    logic                              cur_last;

    function automatic mvs_pkg::int_form_t int_form(input logic [mvs_pkg::INT_W-1:0] u);
        mvs_pkg::int_form_t r;
        r.head = u[7:0];
        r.dcnt = 4'd0;
        if (!u[63]) begin
            priority if (u[63:7] == '0) begin
                r.head = u[7:0];
                r.dcnt = 4'd0;
            end else if (u[63:8] == '0) begin
                r.head = mvs_pkg::MP_UINT8;
                r.dcnt = 4'd1;
            end else if (u[63:16] == '0) begin
                r.head = mvs_pkg::MP_UINT16;
                r.dcnt = 4'd2;
            end else if (u[63:32] == '0) begin
                r.head = mvs_pkg::MP_UINT32;
                r.dcnt = 4'd4;
            end else begin
                r.head = mvs_pkg::MP_UINT64;
                r.dcnt = 4'd8;
            end
        end else begin
            priority if (&u[63:5]) begin
                r.head = u[7:0];
                r.dcnt = 4'd0;
            end else if (&u[63:7]) begin
                r.head = mvs_pkg::MP_INT8;
                r.dcnt = 4'd1;
            end else if (&u[63:15]) begin
                r.head = mvs_pkg::MP_INT16;
                r.dcnt = 4'd2;
            end else if (&u[63:31]) begin
                r.head = mvs_pkg::MP_INT32;
                r.dcnt = 4'd4;
            end else begin
                r.head = mvs_pkg::MP_INT64;
                r.dcnt = 4'd8;
            end
        end
        return r;
    endfunction

    // left-align the low n bytes so the first one sits in the top byte
    function automatic logic [mvs_pkg::INT_W-1:0] align_be(
        input logic [mvs_pkg::INT_W-1:0]  w,
        input logic [mvs_pkg::DCNT_W-1:0] n
    );
        logic [mvs_pkg::INT_W-1:0] r;
        unique case (n)
            4'd1:    r = {w[7:0], 56'd0};
            4'd2:    r = {w[15:0], 48'd0};
            4'd4:    r = {w[31:0], 32'd0};
            default: r = w;
        endcase
        return r;
    endfunction

    assign accept = in_ch.valid && in_ch.ready;
    assign step   = (state_reg != mvs_pkg::ST_IDLE) && (!ovalid_reg || out_ch.ready);

    assign ifrm = int_form(in_ch.int_value);

    always_comb
    begin
        enc       = '0;
        enc.valid = 1'b1;
        enc.word  = in_ch.int_value;
        unique case (in_ch.opcode)
            mvs_pkg::OP_START:
            begin
                enc.head = {frame_header_reg, format_version_reg};
                enc.tcnt = 2'd1;
                enc.tail = {mvs_pkg::MP_OPTIONS, 8'd0};
            end
            mvs_pkg::OP_INT:
            begin
                enc.head = ifrm.head;
                enc.dcnt = ifrm.dcnt;
            end
            mvs_pkg::OP_BOOL:
            begin
                enc.head = in_ch.flag ? mvs_pkg::MP_TRUE : mvs_pkg::MP_FALSE;
            end
            mvs_pkg::OP_F32:
            begin
                enc.head = mvs_pkg::MP_FLOAT32;
                enc.dcnt = 4'd4;
                enc.word = in_ch.raw_bits;
            end
            mvs_pkg::OP_F64:
            begin
                enc.head = mvs_pkg::MP_FLOAT64;
                enc.dcnt = 4'd8;
                enc.word = in_ch.raw_bits;
            end
            mvs_pkg::OP_STR_HDR:
            begin
                enc.word = {32'd0, in_ch.length};
                priority if (in_ch.length[31:5] == '0) begin
                    enc.head = {mvs_pkg::MP_FIXSTR, in_ch.length[4:0]};
                end else if (in_ch.length[31:8] == '0) begin
                    enc.head = mvs_pkg::MP_STR8;
                    enc.dcnt = 4'd1;
                end else if (in_ch.length[31:16] == '0) begin
                    enc.head = mvs_pkg::MP_STR16;
                    enc.dcnt = 4'd2;
                end else begin
                    enc.head = mvs_pkg::MP_STR32;
                    enc.dcnt = 4'd4;
                end
            end
            mvs_pkg::OP_BIN_HDR:
            begin
                enc.word = {32'd0, in_ch.length};
                priority if (in_ch.length[31:8] == '0) begin
                    enc.head = mvs_pkg::MP_BIN8;
                    enc.dcnt = 4'd1;
                end else if (in_ch.length[31:16] == '0) begin
                    enc.head = mvs_pkg::MP_BIN16;
                    enc.dcnt = 4'd2;
                end else begin
                    enc.head = mvs_pkg::MP_BIN32;
                    enc.dcnt = 4'd4;
                end
            end
            mvs_pkg::OP_PAYLOAD:
            begin
                enc.head = in_ch.payload;
            end
            mvs_pkg::OP_OBJ_BEG:
            begin
                enc.head = ifrm.head;
                enc.dcnt = ifrm.dcnt;
                enc.tcnt = 2'd2;
                enc.tail = {mvs_pkg::MP_FIXEXT1, obj_begin_reg};
            end
            mvs_pkg::OP_OBJ_END:
            begin
                enc.head = ifrm.head;
                enc.dcnt = ifrm.dcnt;
                enc.tcnt = 2'd2;
                enc.tail = {mvs_pkg::MP_FIXEXT1, obj_end_reg};
            end
            mvs_pkg::OP_EL_BEG:
            begin
                enc.head = mvs_pkg::MP_FIXEXT2;
                enc.tcnt = 2'd1;
                enc.tail = {elem_begin_reg, 8'd0};
            end
            mvs_pkg::OP_EL_END:
            begin
                enc.head = mvs_pkg::MP_FIXEXT2;
                enc.tcnt = 2'd1;
                enc.tail = {elem_end_reg, 8'd0};
            end
            default:
            begin
                enc.valid = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvs_pkg::ST_IDLE:
            begin
                if (accept && enc.valid)
                    state_next = mvs_pkg::ST_HEAD;
            end
            mvs_pkg::ST_HEAD:
            begin
                if (step) begin
                    priority if (dcnt_reg != '0)
                        state_next = mvs_pkg::ST_DATA;
                    else if (tcnt_reg != '0)
                        state_next = mvs_pkg::ST_TAIL;
                    else
                        state_next = mvs_pkg::ST_IDLE;
                end
            end
            mvs_pkg::ST_DATA:
            begin
                if (step && dcnt_reg == 4'd1)
                    state_next = (tcnt_reg != '0) ? mvs_pkg::ST_TAIL : mvs_pkg::ST_IDLE;
            end
            mvs_pkg::ST_TAIL:
            begin
                if (step && tcnt_reg == 2'd1)
                    state_next = mvs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mvs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        cur_byte    = head_reg;
        cur_last    = 1'b0;
        unique case (state_reg)
            mvs_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            mvs_pkg::ST_HEAD:
            begin
                cur_byte = head_reg;
                cur_last = (dcnt_reg == '0) && (tcnt_reg == '0);
            end
            mvs_pkg::ST_DATA:
            begin
                cur_byte = data_reg[63:56];
                cur_last = (dcnt_reg == 4'd1) && (tcnt_reg == '0);
            end
            mvs_pkg::ST_TAIL:
            begin
                cur_byte = tail_reg[15:8];
                cur_last = (tcnt_reg == 2'd1);
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    assign out_ch.valid    = ovalid_reg;
    assign out_ch.out_byte = obyte_reg;
    assign out_ch.last     = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_header_reg   <= mvs_pkg::RST_FRAME_HEADER;
            format_version_reg <= mvs_pkg::RST_FORMAT_VER;
            obj_begin_reg      <= mvs_pkg::RST_OBJ_BEGIN;
            obj_end_reg        <= mvs_pkg::RST_OBJ_END;
            elem_begin_reg     <= mvs_pkg::RST_ELEM_BEGIN;
            elem_end_reg       <= mvs_pkg::RST_ELEM_END;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mvs_pkg::REG_FRAME_HEADER: frame_header_reg   <= cfg_wdata[3:0];
                mvs_pkg::REG_FORMAT_VER:   format_version_reg <= cfg_wdata[3:0];
                mvs_pkg::REG_OBJ_BEGIN:    obj_begin_reg      <= cfg_wdata;
                mvs_pkg::REG_OBJ_END:      obj_end_reg        <= cfg_wdata;
                mvs_pkg::REG_ELEM_BEGIN:   elem_begin_reg     <= cfg_wdata;
                mvs_pkg::REG_ELEM_END:     elem_end_reg       <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= mvs_pkg::ST_IDLE;
            dcnt_reg   <= '0;
            tcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                dcnt_reg <= enc.dcnt;
                tcnt_reg <= enc.tcnt;
            end else if (step) begin
                if (state_reg == mvs_pkg::ST_DATA)
                    dcnt_reg <= dcnt_reg - 4'd1;
                if (state_reg == mvs_pkg::ST_TAIL)
                    tcnt_reg <= tcnt_reg - 2'd1;
            end
            if (step)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            head_reg <= enc.head;
            data_reg <= align_be(enc.word, enc.dcnt);
            tail_reg <= enc.tail;
        end else if (step) begin
            if (state_reg == mvs_pkg::ST_DATA)
                data_reg <= {data_reg[55:0], 8'd0};
            if (state_reg == mvs_pkg::ST_TAIL)
                tail_reg <= {tail_reg[7:0], 8'd0};
        end
        if (step) begin
            obyte_reg <= cur_byte;
            olast_reg <= cur_last;
        end
    end

endmodule

@@ src/mvs_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvs_checker
// Port-level checks of the serializer, bound to the top level.
// ---------------------------------------------------------------------------
`include "msgpack_value_serializer_top_defines.svh"

module mvs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [mvs_pkg::OPCODE_W-1:0]    in_opcode,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [mvs_pkg::BYTE_W-1:0]      out_byte,
    input logic                            out_last
);

    // output word held while stalled
    `MVS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output word dropped while stalled")
    `MVS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last), "stalled output word changed")
    // a new item is taken only after the previous item's final byte
    `MVS_ASSERT(a_ready_last, in_ready && out_valid |-> out_last, "input ready while item bytes are still pending")
    // a defined opcode occupies the block after acceptance
    `MVS_ASSERT(a_busy_after, in_valid && in_ready && (in_opcode <= mvs_pkg::OP_EL_END) |=> !in_ready, "block ready right after accepting an item")
    // the reset edge clears the output register
    `MVS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid during reset")

endmodule

bind msgpack_value_serializer_top mvs_checker u_mvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
);

@@ tb/sv/tb_msgpack_value_serializer_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_msgpack_value_serializer_top
// Drives typed values into the serializer and checks every output byte and
// last mark against an in-bench encoder. Directed corners of each value kind
// and of the registers come first. Then a long output hold fills the block.
// Then random records run under several register settings, with random idle
// bursts on both channels except in the final phase.
// ---------------------------------------------------------------------------
module tb_msgpack_value_serializer_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 255;

    localparam logic [mvs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [mvs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [mvs_pkg::OPCODE_W-1:0]  OP_SPARE_LO  = 4'd12;
    localparam logic [mvs_pkg::OPCODE_W-1:0]  OP_SPARE_HI  = 4'd15;

    typedef struct packed {
        logic [mvs_pkg::OPCODE_W-1:0] opcode;
        logic [mvs_pkg::INT_W-1:0]    int_value;
        logic [mvs_pkg::RAW_W-1:0]    raw_bits;
        logic                         flag;
        logic [mvs_pkg::LEN_W-1:0]    length;
        logic [mvs_pkg::BYTE_W-1:0]   payload;
    } value_word_t;

    typedef struct packed {
        logic [mvs_pkg::BYTE_W-1:0] out_byte;
        logic                       last;
    } enc_byte_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [mvs_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [mvs_pkg::CFG_DATA_W-1:0] cfg_wdata;

    mvs_in_if  in_ch ();
    mvs_out_if out_ch ();

    msgpack_value_serializer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // encoder copy of the registers
    logic [3:0]                 hdr_nibble;
    logic [3:0]                 ver_nibble;
    logic [mvs_pkg::BYTE_W-1:0] obj_begin_type;
    logic [mvs_pkg::BYTE_W-1:0] obj_end_type;
    logic [mvs_pkg::BYTE_W-1:0] elem_begin_type;
    logic [mvs_pkg::BYTE_W-1:0] elem_end_type;

    logic [mvs_pkg::BYTE_W-1:0] item_bytes[$];
    enc_byte_t                  expected_bytes[$];
    enc_byte_t                  next_byte;

    int errors        = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int idle_cycles   = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_request  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- encoder
    function automatic void emit_be(logic [63:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            item_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void emit_int(logic [63:0] u);
        if (!u[63])
        begin
            if (u <= 64'h7f)
                item_bytes.push_back(u[7:0]);
            else if (u <= 64'hff)
            begin
                item_bytes.push_back(mvs_pkg::MP_UINT8);
                emit_be(u, 1);
            end
            else if (u <= 64'hffff)
            begin
                item_bytes.push_back(mvs_pkg::MP_UINT16);
                emit_be(u, 2);
            end
            else if (u <= 64'hffff_ffff)
            begin
                item_bytes.push_back(mvs_pkg::MP_UINT32);
                emit_be(u, 4);
            end
            else
            begin
                item_bytes.push_back(mvs_pkg::MP_UINT64);
                emit_be(u, 8);
            end
        end
        else
        begin
            if (u >= 64'hffff_ffff_ffff_ffe0)
                item_bytes.push_back(u[7:0]);
            else if (u >= 64'hffff_ffff_ffff_ff80)
            begin
                item_bytes.push_back(mvs_pkg::MP_INT8);
                emit_be(u, 1);
            end
            else if (u >= 64'hffff_ffff_ffff_8000)
            begin
                item_bytes.push_back(mvs_pkg::MP_INT16);
                emit_be(u, 2);
            end
            else if (u >= 64'hffff_ffff_8000_0000)
            begin
                item_bytes.push_back(mvs_pkg::MP_INT32);
                emit_be(u, 4);
            end
            else
            begin
                item_bytes.push_back(mvs_pkg::MP_INT64);
                emit_be(u, 8);
            end
        end
    endfunction

    function automatic void encode_word(value_word_t w);
        enc_byte_t e;
        item_bytes.delete();
        case (w.opcode)
            mvs_pkg::OP_START:
            begin
                item_bytes.push_back({hdr_nibble, ver_nibble});
                item_bytes.push_back(mvs_pkg::MP_OPTIONS);
            end
            mvs_pkg::OP_INT:
                emit_int(w.int_value);
            mvs_pkg::OP_BOOL:
                item_bytes.push_back(w.flag ? mvs_pkg::MP_TRUE : mvs_pkg::MP_FALSE);
            mvs_pkg::OP_F32:
            begin
                item_bytes.push_back(mvs_pkg::MP_FLOAT32);
                emit_be(w.raw_bits, 4);
            end
            mvs_pkg::OP_F64:
            begin
                item_bytes.push_back(mvs_pkg::MP_FLOAT64);
                emit_be(w.raw_bits, 8);
            end
            mvs_pkg::OP_STR_HDR:
            begin
                if (w.length <= 32'h1f)
                    item_bytes.push_back({mvs_pkg::MP_FIXSTR, w.length[4:0]});
                else if (w.length <= 32'hff)
                begin
                    item_bytes.push_back(mvs_pkg::MP_STR8);
                    emit_be({32'd0, w.length}, 1);
                end
                else if (w.length <= 32'hffff)
                begin
                    item_bytes.push_back(mvs_pkg::MP_STR16);
                    emit_be({32'd0, w.length}, 2);
                end
                else
                begin
                    item_bytes.push_back(mvs_pkg::MP_STR32);
                    emit_be({32'd0, w.length}, 4);
                end
            end
            mvs_pkg::OP_BIN_HDR:
            begin
                if (w.length <= 32'hff)
                begin
                    item_bytes.push_back(mvs_pkg::MP_BIN8);
                    emit_be({32'd0, w.length}, 1);
                end
                else if (w.length <= 32'hffff)
                begin
                    item_bytes.push_back(mvs_pkg::MP_BIN16);
                    emit_be({32'd0, w.length}, 2);
                end
                else
                begin
                    item_bytes.push_back(mvs_pkg::MP_BIN32);
                    emit_be({32'd0, w.length}, 4);
                end
            end
            mvs_pkg::OP_PAYLOAD:
                item_bytes.push_back(w.payload);
            mvs_pkg::OP_OBJ_BEG:
            begin
                emit_int(w.int_value);
                item_bytes.push_back(mvs_pkg::MP_FIXEXT1);
                item_bytes.push_back(obj_begin_type);
            end
            mvs_pkg::OP_OBJ_END:
            begin
                emit_int(w.int_value);
                item_bytes.push_back(mvs_pkg::MP_FIXEXT1);
                item_bytes.push_back(obj_end_type);
            end
            mvs_pkg::OP_EL_BEG:
            begin
                item_bytes.push_back(mvs_pkg::MP_FIXEXT2);
                item_bytes.push_back(elem_begin_type);
            end
            mvs_pkg::OP_EL_END:
            begin
                item_bytes.push_back(mvs_pkg::MP_FIXEXT2);
                item_bytes.push_back(elem_end_type);
            end
            default: ;
        endcase
        foreach (item_bytes[i])
        begin
            e.out_byte = item_bytes[i];
            e.last     = (i == item_bytes.size() - 1);
            expected_bytes.push_back(e);
        end
    endfunction

    // ---------------------------------------------------------- random values
    function automatic logic [63:0] rand_int_value();
        logic [63:0] v;
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 1))
            v = ~v;
        return v;
    endfunction

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 40);
            6:                return $urandom_range(0, 300);
            7:                return $urandom_range(0, 70000);
            default:          return $urandom;
        endcase
    endfunction

    function automatic value_word_t rand_word(logic [mvs_pkg::OPCODE_W-1:0] op);
        value_word_t w;
        w.opcode    = op;
        w.int_value = rand_int_value();
        w.raw_bits  = {$urandom, $urandom};
        w.flag      = 1'($urandom_range(0, 1));
        w.length    = rand_length();
        w.payload   = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // ------------------------------------------------------------ bus drivers
    task automatic write_reg(input logic [mvs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] data);
        cfg_addr  = idx;
        cfg_wdata = data;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            mvs_pkg::REG_FRAME_HEADER: hdr_nibble      = data[3:0];
            mvs_pkg::REG_FORMAT_VER:   ver_nibble      = data[3:0];
            mvs_pkg::REG_OBJ_BEGIN:    obj_begin_type  = data;
            mvs_pkg::REG_OBJ_END:      obj_end_type    = data;
            mvs_pkg::REG_ELEM_BEGIN:   elem_begin_type = data;
            mvs_pkg::REG_ELEM_END:     elem_end_type   = data;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [7:0] data);
        write_reg(mvs_pkg::REG_FRAME_HEADER, data);
        write_reg(mvs_pkg::REG_FORMAT_VER, data);
        write_reg(mvs_pkg::REG_OBJ_BEGIN, data);
        write_reg(mvs_pkg::REG_OBJ_END, data);
        write_reg(mvs_pkg::REG_ELEM_BEGIN, data);
        write_reg(mvs_pkg::REG_ELEM_END, data);
    endtask

    // entered and left at a falling edge; valid stays up for the next word
    task automatic send_word(input value_word_t w);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_ch.opcode    = w.opcode;
        in_ch.int_value = w.int_value;
        in_ch.raw_bits  = w.raw_bits;
        in_ch.flag      = w.flag;
        in_ch.length    = w.length;
        in_ch.payload   = w.payload;
        in_ch.valid     = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        encode_word(w);
        if (w.opcode <= mvs_pkg::OP_EL_END)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_int(input logic [mvs_pkg::OPCODE_W-1:0] op, input logic [63:0] v);
        value_word_t w;
        w = rand_word(op);
        w.int_value = v;
        send_word(w);
    endtask

    task automatic send_len(input logic [mvs_pkg::OPCODE_W-1:0] op, input logic [31:0] len);
        value_word_t w;
        w = rand_word(op);
        w.length = len;
        send_word(w);
    endtask

    task automatic settle();
        in_ch.valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------ sequences
    task automatic send_scalar();
        case ($urandom_range(0, 4))
            0, 1:    send_word(rand_word(mvs_pkg::OP_INT));
            2:       send_word(rand_word(mvs_pkg::OP_BOOL));
            3:       send_word(rand_word(mvs_pkg::OP_F32));
            default: send_word(rand_word(mvs_pkg::OP_F64));
        endcase
    endtask

    // header then its payload; long headers get a truncated payload
    task automatic send_blob(input logic [mvs_pkg::OPCODE_W-1:0] op);
        logic [31:0] len;
        int          npay;
        len  = rand_length();
        npay = (len > 8) ? int'($urandom_range(0, 3)) : int'(len);
        send_len(op, len);
        repeat (npay) send_word(rand_word(mvs_pkg::OP_PAYLOAD));
    endtask

    task automatic send_object();
        logic [63:0] id;
        id = rand_int_value();
        send_int(mvs_pkg::OP_OBJ_BEG, id);
        repeat ($urandom_range(1, 3))
        begin
            send_word(rand_word(mvs_pkg::OP_EL_BEG));
            if ($urandom_range(0, 2) == 0)
                send_blob(mvs_pkg::OP_STR_HDR);
            else
                send_scalar();
            send_word(rand_word(mvs_pkg::OP_EL_END));
        end
        send_int(mvs_pkg::OP_OBJ_END, id);
    endtask

    task automatic run_random_stream(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 9))
                0:       send_word(rand_word(mvs_pkg::OP_START));
                1, 2, 3: send_scalar();
                4:       send_blob(mvs_pkg::OP_STR_HDR);
                5:       send_blob(mvs_pkg::OP_BIN_HDR);
                6, 7:    send_object();
                default: send_word(rand_word(4'($urandom_range(0, OP_SPARE_HI))));
            endcase
        end
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_reset_defaults();
        send_word(rand_word(mvs_pkg::OP_START));
        send_word(rand_word(mvs_pkg::OP_EL_BEG));
        send_word(rand_word(mvs_pkg::OP_EL_END));
        send_int(mvs_pkg::OP_OBJ_BEG, 64'h0);
        send_int(mvs_pkg::OP_OBJ_END, 64'hffff_ffff_ffff_ffff);
        settle();
    endtask

    task automatic test_register_extremes();
        write_all_regs(8'hff);
        send_word(rand_word(mvs_pkg::OP_START));
        send_int(mvs_pkg::OP_OBJ_BEG, 64'h7f);
        send_int(mvs_pkg::OP_OBJ_END, 64'h80);
        send_word(rand_word(mvs_pkg::OP_EL_BEG));
        send_word(rand_word(mvs_pkg::OP_EL_END));
        settle();
        write_all_regs(8'h00);
        send_word(rand_word(mvs_pkg::OP_START));
        send_int(mvs_pkg::OP_OBJ_END, 64'hffff_ffff_ffff_ffdf);
        send_word(rand_word(mvs_pkg::OP_EL_END));
        settle();
        // nibble registers drop the upper bits; spare indexes change nothing
        write_reg(mvs_pkg::REG_FRAME_HEADER, 8'h3c);
        write_reg(mvs_pkg::REG_FORMAT_VER, 8'ha5);
        write_reg(REG_SPARE_LO, 8'h5a);
        write_reg(REG_SPARE_HI, 8'ha5);
        send_word(rand_word(mvs_pkg::OP_START));
        send_int(mvs_pkg::OP_OBJ_BEG, 64'h8000_0000_0000_0000);
        send_word(rand_word(mvs_pkg::OP_EL_BEG));
        settle();
    endtask

    task automatic test_value_extremes();
        logic [63:0] corners [13];
        value_word_t w;
        corners = '{64'h0000_0000_0000_007f, 64'h0000_0000_0000_0080,
                    64'h0000_0000_0000_ffff, 64'h0000_0000_0001_0000,
                    64'h0000_0001_0000_0000, 64'h7fff_ffff_ffff_ffff,
                    64'hffff_ffff_ffff_ffe0, 64'hffff_ffff_ffff_ffdf,
                    64'hffff_ffff_ffff_ff7f, 64'hffff_ffff_ffff_7fff,
                    64'hffff_ffff_8000_0000, 64'hffff_ffff_7fff_ffff,
                    64'h8000_0000_0000_0000};
        foreach (corners[i])
            send_int(mvs_pkg::OP_INT, corners[i]);
        w = rand_word(mvs_pkg::OP_BOOL);
        w.flag = 1'b0;
        send_word(w);
        w.flag = 1'b1;
        send_word(w);
        w = rand_word(mvs_pkg::OP_F32);
        w.raw_bits = '1;
        send_word(w);
        w = rand_word(mvs_pkg::OP_F64);
        w.raw_bits = 64'h8000_0000_0000_0001;
        send_word(w);
        send_len(mvs_pkg::OP_STR_HDR, 32'd31);
        send_len(mvs_pkg::OP_STR_HDR, 32'd32);
        send_len(mvs_pkg::OP_STR_HDR, 32'h0001_0000);
        send_len(mvs_pkg::OP_BIN_HDR, 32'h0000_ffff);
        send_len(mvs_pkg::OP_BIN_HDR, 32'hffff_ffff);
        // payload bytes with no header ahead of them
        w = rand_word(mvs_pkg::OP_PAYLOAD);
        w.payload = 8'h00;
        send_word(w);
        w.payload = 8'hff;
        send_word(w);
        send_word(rand_word(OP_SPARE_LO));
        send_word(rand_word(OP_SPARE_HI));
        settle();
    endtask

    task automatic test_backpressure();
        hold_request = HOLD_CYCLES;
        repeat (30)
        begin
            if ($urandom_range(0, 1))
                send_word(rand_word(mvs_pkg::OP_F64));
            else
                send_word(rand_word(mvs_pkg::OP_OBJ_BEG));
        end
        settle();
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 3; phase++)
        begin
            write_reg(mvs_pkg::REG_FRAME_HEADER, 8'($urandom_range(0, 255)));
            write_reg(mvs_pkg::REG_FORMAT_VER, 8'($urandom_range(0, 255)));
            write_reg(mvs_pkg::REG_OBJ_BEGIN, 8'($urandom_range(0, 255)));
            write_reg(mvs_pkg::REG_OBJ_END, 8'($urandom_range(0, 255)));
            write_reg(mvs_pkg::REG_ELEM_BEGIN, 8'($urandom_range(0, 255)));
            write_reg(mvs_pkg::REG_ELEM_END, 8'($urandom_range(0, 255)));
            if (phase == 2)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(5, 30);
                stall_pct = $urandom_range(5, 30);
            end
            run_random_stream(RANDOM_ITEMS / 3);
            settle();
        end
    endtask

    // ----------------------------------------------------------- output side
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                out_ch.ready = 1'b0;
                for (int c = 0; c < hold_request; c++)
                    @(negedge clk);
                hold_request = 0;
                out_ch.ready = 1'b1;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_ch.ready = 1'b1;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: out_byte %h last %b", out_ch.out_byte, out_ch.last);
                errors++;
            end
            else
            begin
                next_byte = expected_bytes.pop_front();
                if (out_ch.out_byte !== next_byte.out_byte)
                begin
                    $error("out_byte: expected %h, actual %h",
                           next_byte.out_byte, out_ch.out_byte);
                    errors++;
                end
                if (out_ch.last !== next_byte.last)
                begin
                    $error("last: expected %b, actual %b", next_byte.last, out_ch.last);
                    errors++;
                end
                bytes_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------ main
    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.opcode    = '0;
        in_ch.int_value = '0;
        in_ch.raw_bits  = '0;
        in_ch.flag      = 1'b0;
        in_ch.length    = '0;
        in_ch.payload   = '0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        hdr_nibble      = mvs_pkg::RST_FRAME_HEADER;
        ver_nibble      = mvs_pkg::RST_FORMAT_VER;
        obj_begin_type  = mvs_pkg::RST_OBJ_BEGIN;
        obj_end_type    = mvs_pkg::RST_OBJ_END;
        elem_begin_type = mvs_pkg::RST_ELEM_BEGIN;
        elem_end_type   = mvs_pkg::RST_ELEM_END;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        gap_pct   = 15;
        stall_pct = 15;
        test_reset_defaults();
        test_register_extremes();
        test_value_extremes();
        test_backpressure();
        test_random_stream();
        settle();
        $display("Sent %0d values over all kinds and register settings; %0d bytes checked.",
                 items_sent, bytes_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/mvs_pkg.sv
src/mvs_in_if.sv
src/mvs_out_if.sv
src/msgpack_value_serializer_top.sv
src/mvs_checker.sv
tb/sv/tb_msgpack_value_serializer_top.sv
